// ===== sv/text_terminal_writer_defines.svh =====
`ifndef TEXT_TERMINAL_WRITER_DEFINES_SVH
`define TEXT_TERMINAL_WRITER_DEFINES_SVH

// clocked check, switched off while reset is held
`define TTW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never be seen at a clock edge
`define TTW_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `TTW_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== sv/ttw_pkg.sv =====
`timescale 1ns / 1ps

package ttw_pkg;

    // field widths of the words on the ports
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int COORD_W    = 8;
    localparam int RANGE_W    = 11;
    localparam int IDX_OUT_W  = 11;
    localparam int COL_OUT_W  = 7;
    localparam int ROW_OUT_W  = 5;
    localparam int COLOUR_W   = 4;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
    localparam logic [OP_W-1:0] OP_GOTO = 2'd1;
    localparam logic [OP_W-1:0] OP_FILL = 2'd2;
    localparam logic [OP_W-1:0] OP_READ = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FG = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 8'd1;

    localparam logic [COLOUR_W-1:0] FG_RESET = 4'hF;
    localparam logic [COLOUR_W-1:0] BG_RESET = 4'h0;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] FILL_CHAR    = 8'h00;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F00;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [CHAR_W-1:0]  char_code;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [RANGE_W-1:0] range_start;
        logic [RANGE_W-1:0] range_end;
    } req_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] cursor_index;
        logic [COL_OUT_W-1:0] cursor_column;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic                 accepted;
        logic [CHAR_W-1:0]    cell_char;
        logic [ATTR_W-1:0]    cell_attr;
    } result_t;

endpackage

// ===== sv/text_terminal_writer.sv =====
`timescale 1ns / 1ps

// Character-cell text screen writer, LINE_WIDTH x LINE_COUNT cells of 16 bits
// (character low byte, attribute high byte). After reset a clearing pass
// writes the blank cell into all LINE_WIDTH*LINE_COUNT cells, one per cycle;
// s_ready stays low meanwhile, while the configuration port takes writes at
// once. One word is worked on at a time: after acceptance the sequencer
// executes the word, goes through a read wait for a read of a cell on the
// screen, through a fill loop for fill and, for a put that runs past the last
// line, through a scroll loop that moves the lines up, and then offers the
// result word to the output register, waiting while that register holds a
// word not yet taken. s_ready comes back as the result word enters the output
// register, so no new word is taken while the last one is in the sequencer.
// The fill and scroll loops go through the single write port of the cell
// memory one cell per cycle. A result word waits in the output register while
// the next word is accepted.
module text_terminal_writer #(
    parameter int LINE_WIDTH = 80,
    parameter int LINE_COUNT = 25
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ttw_pkg::OP_W-1:0]        s_operation,
    input  logic [ttw_pkg::CHAR_W-1:0]      s_char_code,
    input  logic [ttw_pkg::COORD_W-1:0]     s_column,
    input  logic [ttw_pkg::COORD_W-1:0]     s_row,
    input  logic [ttw_pkg::RANGE_W-1:0]     s_range_start,
    input  logic [ttw_pkg::RANGE_W-1:0]     s_range_end,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ttw_pkg::IDX_OUT_W-1:0]   m_cursor_index,
    output logic [ttw_pkg::COL_OUT_W-1:0]   m_cursor_column,
    output logic [ttw_pkg::ROW_OUT_W-1:0]   m_cursor_row,
    output logic                            m_accepted,
    output logic [ttw_pkg::CHAR_W-1:0]      m_cell_char,
    output logic [ttw_pkg::ATTR_W-1:0]      m_cell_attr,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ttw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ttw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SCREEN = LINE_WIDTH * LINE_COUNT;
    localparam int AW     = $clog2(SCREEN);
    localparam int CW     = $clog2(SCREEN + 1);

    logic [ttw_pkg::COLOUR_W-1:0] fg_reg, fg_next;
    logic [ttw_pkg::COLOUR_W-1:0] bg_reg, bg_next;
    logic                         m_valid_reg, m_valid_next;
    ttw_pkg::result_t             out_reg, out_next;

    ttw_pkg::req_t                req;
    ttw_pkg::result_t             res;
    logic                         res_valid, res_ready;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr, mem_raddr;
    logic [ttw_pkg::CELL_W-1:0]   mem_wdata, mem_rdata;

    assign req.operation   = s_operation;
    assign req.char_code   = s_char_code;
    assign req.column      = s_column;
    assign req.row         = s_row;
    assign req.range_start = s_range_start;
    assign req.range_end   = s_range_end;

    // colour registers
    assign cfg_ready = 1'b1;
    always_comb begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_valid) begin
            if (cfg_index == ttw_pkg::CFG_FG) begin
                fg_next = cfg_data[ttw_pkg::COLOUR_W-1:0];
            end else if (cfg_index == ttw_pkg::CFG_BG) begin
                bg_next = cfg_data[ttw_pkg::COLOUR_W-1:0];
            end
        end
    end

    // output register
    assign res_ready = !m_valid_reg || m_ready;
    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg      <= ttw_pkg::FG_RESET;
            bg_reg      <= ttw_pkg::BG_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            fg_reg      <= fg_next;
            bg_reg      <= bg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_cursor_index  = out_reg.cursor_index;
    assign m_cursor_column = out_reg.cursor_column;
    assign m_cursor_row    = out_reg.cursor_row;
    assign m_accepted      = out_reg.accepted;
    assign m_cell_char     = out_reg.cell_char;
    assign m_cell_attr     = out_reg.cell_attr;

    ttw_seq #(
        .LINE_WIDTH (LINE_WIDTH),
        .LINE_COUNT (LINE_COUNT),
        .SCREEN     (SCREEN),
        .AW         (AW),
        .CW         (CW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (req),
        .attr      ({bg_reg, fg_reg}),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ttw_cell_ram #(
        .DEPTH (SCREEN),
        .AW    (AW),
        .DW    (ttw_pkg::CELL_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ===== sv/ttw_cell_ram.sv =====
`timescale 1ns / 1ps

module ttw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11,
    parameter int DW    = 16
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // one write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // one registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/ttw_seq.sv =====
`timescale 1ns / 1ps
`include "text_terminal_writer_defines.svh"

module ttw_seq #(
    parameter int LINE_WIDTH = 80,
    parameter int LINE_COUNT = 25,
    parameter int SCREEN     = 2000,
    parameter int AW         = 11,
    parameter int CW         = 11
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  ttw_pkg::req_t              req,
    input  logic [ttw_pkg::ATTR_W-1:0] attr,
    output logic                       res_valid,
    input  logic                       res_ready,
    output ttw_pkg::result_t           res,
    output logic                       mem_we,
    output logic [AW-1:0]              mem_waddr,
    output logic [ttw_pkg::CELL_W-1:0] mem_wdata,
    output logic [AW-1:0]              mem_raddr,
    input  logic [ttw_pkg::CELL_W-1:0] mem_rdata
);

    localparam int COLW = $clog2(LINE_WIDTH);
    localparam int ROWW = (LINE_COUNT > 2) ? $clog2(LINE_COUNT) : 1;
    localparam int XW   = (CW > ttw_pkg::RANGE_W) ? CW : ttw_pkg::RANGE_W;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_FILL   = 3'd3;
    localparam logic [2:0] S_SCROLL = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]                 state_reg, state_next;
    logic [CW-1:0]              addr_reg, addr_next;
    logic [CW-1:0]              limit_reg, limit_next;
    logic [AW-1:0]              wr_addr_reg, wr_addr_next;
    logic                       wr_pend_reg, wr_pend_next;
    logic [AW-1:0]              cur_idx_reg, cur_idx_next;
    logic [COLW-1:0]            cur_col_reg, cur_col_next;
    logic [ROWW-1:0]            cur_row_reg, cur_row_next;
    ttw_pkg::req_t              req_reg, req_next;
    logic                       acc_reg, acc_next;
    logic [ttw_pkg::CELL_W-1:0] cell_reg, cell_next;

    // shared address step for the clear, fill and scroll loops
    logic [CW-1:0] addr_inc;
    assign addr_inc = addr_reg + CW'(1);

    // cursor arithmetic
    logic          newline, wrap, last_row, col_ok, row_ok;
    logic [AW-1:0] idx_inc, line_start, goto_idx;
    logic [XW-1:0] start_x, end_x, end_clamp;

    assign newline    = (req_reg.char_code == ttw_pkg::NEWLINE_CODE);
    assign wrap       = newline || (cur_col_reg == COLW'(LINE_WIDTH - 1));
    assign last_row   = (cur_row_reg == ROWW'(LINE_COUNT - 1));
    assign idx_inc    = cur_idx_reg + AW'(1);
    assign line_start = cur_idx_reg - AW'(cur_col_reg);
    assign col_ok     = ({1'b0, req_reg.column} < 9'(LINE_WIDTH));
    assign row_ok     = ({1'b0, req_reg.row} < 9'(LINE_COUNT));
    assign goto_idx   = AW'(req_reg.row) * AW'(LINE_WIDTH) + AW'(req_reg.column);
    assign start_x    = XW'(req_reg.range_start);
    assign end_x      = XW'(req_reg.range_end);
    assign end_clamp  = (end_x > XW'(SCREEN)) ? XW'(SCREEN) : end_x;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        limit_next   = limit_reg;
        wr_addr_next = wr_addr_reg;
        wr_pend_next = wr_pend_reg;
        cur_idx_next = cur_idx_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        req_next     = req_reg;
        acc_next     = acc_reg;
        cell_next    = cell_reg;
        req_ready    = 1'b0;
        res_valid    = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = addr_reg[AW-1:0];
        mem_wdata    = ttw_pkg::BLANK_CELL;
        mem_raddr    = addr_reg[AW-1:0];

        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                addr_next = addr_inc;
                if (addr_inc == CW'(SCREEN)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    req_next   = req;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                acc_next   = 1'b1;
                cell_next  = '0;
                state_next = S_FINISH;
                case (req_reg.operation)
                    ttw_pkg::OP_PUT: begin
                        if (!newline) begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_idx_reg;
                            mem_wdata = {attr, req_reg.char_code};
                        end
                        if (!wrap) begin
                            cur_idx_next = idx_inc;
                            cur_col_next = cur_col_reg + COLW'(1);
                        end else begin
                            cur_col_next = '0;
                            if (last_row) begin
                                // past the end: lines move up, cursor drops a line
                                cur_idx_next = newline ? line_start
                                                       : idx_inc - AW'(LINE_WIDTH);
                                addr_next    = CW'(LINE_WIDTH);
                                wr_pend_next = 1'b0;
                                state_next   = S_SCROLL;
                            end else begin
                                cur_idx_next = newline ? line_start + AW'(LINE_WIDTH)
                                                       : idx_inc;
                                cur_row_next = cur_row_reg + ROWW'(1);
                            end
                        end
                    end
                    ttw_pkg::OP_GOTO: begin
                        if (col_ok && row_ok) begin
                            cur_idx_next = goto_idx;
                            cur_col_next = COLW'(req_reg.column);
                            cur_row_next = ROWW'(req_reg.row);
                        end else begin
                            acc_next = 1'b0;
                        end
                    end
                    ttw_pkg::OP_FILL: begin
                        if (start_x < end_clamp) begin
                            addr_next  = CW'(start_x);
                            limit_next = CW'(end_clamp);
                            state_next = S_FILL;
                        end
                    end
                    default: begin
                        if (start_x < XW'(SCREEN)) begin
                            mem_raddr  = AW'(req_reg.range_start);
                            state_next = S_RDWAIT;
                        end
                    end
                endcase
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = {attr, ttw_pkg::FILL_CHAR};
                addr_next = addr_inc;
                if (addr_inc == limit_reg) begin
                    state_next = S_FINISH;
                end
            end
            S_SCROLL: begin
                // read one line below, write the word read in the previous cycle
                mem_we    = wr_pend_reg;
                mem_waddr = wr_addr_reg;
                mem_wdata = mem_rdata;
                if (addr_reg != CW'(SCREEN)) begin
                    wr_addr_next = AW'(addr_reg - CW'(LINE_WIDTH));
                    wr_pend_next = 1'b1;
                    addr_next    = addr_inc;
                end else begin
                    wr_pend_next = 1'b0;
                    state_next   = S_FINISH;
                end
            end
            S_RDWAIT: begin
                cell_next  = mem_rdata;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            addr_reg    <= '0;
            limit_reg   <= '0;
            wr_addr_reg <= '0;
            wr_pend_reg <= 1'b0;
            cur_idx_reg <= '0;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            limit_reg   <= limit_next;
            wr_addr_reg <= wr_addr_next;
            wr_pend_reg <= wr_pend_next;
            cur_idx_reg <= cur_idx_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        req_reg  <= req_next;
        acc_reg  <= acc_next;
        cell_reg <= cell_next;
    end

    // result word
    always_comb begin
        res.cursor_index  = ttw_pkg::IDX_OUT_W'(cur_idx_reg);
        res.cursor_column = ttw_pkg::COL_OUT_W'(cur_col_reg);
        res.cursor_row    = ttw_pkg::ROW_OUT_W'(cur_row_reg);
        res.accepted      = acc_reg;
        res.cell_char     = cell_reg[ttw_pkg::CHAR_W-1:0];
        res.cell_attr     = cell_reg[ttw_pkg::CELL_W-1:ttw_pkg::CHAR_W];
    end

    `TTW_ASSERT(a_cursor_in_screen, aclk, aresetn, cur_idx_reg < AW'(SCREEN), "cursor off screen")
    `TTW_ASSERT(a_cursor_coords, aclk, aresetn, cur_idx_reg == AW'(cur_row_reg) * AW'(LINE_WIDTH) + AW'(cur_col_reg), "cursor index and coordinates disagree")
    `TTW_ASSERT_NEVER(a_scroll_waddr, aclk, aresetn, (state_reg == S_SCROLL) && mem_we && (mem_waddr >= AW'(SCREEN - LINE_WIDTH)), "scroll writes into last line")
    `TTW_ASSERT(a_finish_handover, aclk, aresetn, (state_reg == S_FINISH) && res_ready |=> (state_reg == S_IDLE), "result taken but sequencer not idle")

endmodule

// ===== bench/text_terminal_writer_tb.sv =====
`timescale 1ns / 1ps

module text_terminal_writer_tb;

    localparam int LINE_WIDTH  = 80;
    localparam int LINE_COUNT  = 25;
    localparam int SCREEN_SIZE = LINE_WIDTH * LINE_COUNT;
    localparam int HOLD_CYCLES = 400;

    // screen model and store of expected result words
    class terminal_scoreboard;
        logic [ttw_pkg::CELL_W-1:0]   cells [SCREEN_SIZE];
        int                           cursor;
        logic [ttw_pkg::COLOUR_W-1:0] fg;
        logic [ttw_pkg::COLOUR_W-1:0] bg;
        ttw_pkg::result_t             expected_q [$];
        int                           fails;
        int                           checked;
        int                           op_count [4];
        int                           scrolls;
        int                           rejected;
        int                           reg_writes;

        function new();
            for (int i = 0; i < SCREEN_SIZE; i++) cells[i] = ttw_pkg::BLANK_CELL;
            cursor     = 0;
            fg         = ttw_pkg::FG_RESET;
            bg         = ttw_pkg::BG_RESET;
            fails      = 0;
            checked    = 0;
            scrolls    = 0;
            rejected   = 0;
            reg_writes = 0;
            for (int i = 0; i < 4; i++) op_count[i] = 0;
        endfunction

        function void write_reg(logic [ttw_pkg::CFG_IDX_W-1:0] index,
                                logic [ttw_pkg::CFG_DATA_W-1:0] data);
            reg_writes++;
            if (index == ttw_pkg::CFG_FG) fg = data[ttw_pkg::COLOUR_W-1:0];
            else if (index == ttw_pkg::CFG_BG) bg = data[ttw_pkg::COLOUR_W-1:0];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // work out the effect of one accepted word and queue its result
        function void note_word(ttw_pkg::req_t w);
            ttw_pkg::result_t           res;
            logic [ttw_pkg::ATTR_W-1:0] attr;
            logic [ttw_pkg::CELL_W-1:0] rd_cell;
            bit                         have_cell;
            int                         stop;
            attr      = {bg, fg};
            have_cell = 0;
            rd_cell   = '0;
            res       = '0;
            res.accepted = 1'b1;
            op_count[w.operation]++;
            case (w.operation)
                ttw_pkg::OP_PUT: begin
                    if (w.char_code == ttw_pkg::NEWLINE_CODE) begin
                        cursor = cursor - (cursor % LINE_WIDTH) + LINE_WIDTH;
                    end else begin
                        cells[cursor] = {attr, w.char_code};
                        cursor++;
                    end
                    // lines move up, the last line keeps its contents
                    if (cursor >= SCREEN_SIZE) begin
                        for (int i = 0; i < SCREEN_SIZE - LINE_WIDTH; i++)
                            cells[i] = cells[i + LINE_WIDTH];
                        cursor -= LINE_WIDTH;
                        scrolls++;
                    end
                end
                ttw_pkg::OP_GOTO: begin
                    if (w.column < LINE_WIDTH && w.row < LINE_COUNT) begin
                        cursor = int'(w.row) * LINE_WIDTH + int'(w.column);
                    end else begin
                        res.accepted = 1'b0;
                        rejected++;
                    end
                end
                ttw_pkg::OP_FILL: begin
                    stop = (w.range_end > SCREEN_SIZE) ? SCREEN_SIZE : int'(w.range_end);
                    for (int i = int'(w.range_start); i < stop; i++)
                        cells[i] = {attr, ttw_pkg::FILL_CHAR};
                end
                default: begin
                    if (w.range_start < SCREEN_SIZE) begin
                        rd_cell   = cells[w.range_start];
                        have_cell = 1;
                    end
                end
            endcase
            res.cursor_index  = ttw_pkg::IDX_OUT_W'(cursor);
            res.cursor_column = ttw_pkg::COL_OUT_W'(cursor % LINE_WIDTH);
            res.cursor_row    = ttw_pkg::ROW_OUT_W'(cursor / LINE_WIDTH);
            res.cell_char     = have_cell ? rd_cell[ttw_pkg::CHAR_W-1:0] : '0;
            res.cell_attr     = have_cell ? rd_cell[ttw_pkg::CELL_W-1:ttw_pkg::CHAR_W] : '0;
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [15:0] exp, logic [15:0] got);
            if (got !== exp) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, got);
                fails++;
            end
        endfunction

        function void check_word(ttw_pkg::result_t got);
            ttw_pkg::result_t exp;
            if (expected_q.size() == 0) begin
                $display("%0t: result word with nothing expected, actual %p", $time, got);
                fails++;
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            compare_field("cursor_index", 16'(exp.cursor_index), 16'(got.cursor_index));
            compare_field("cursor_column", 16'(exp.cursor_column), 16'(got.cursor_column));
            compare_field("cursor_row", 16'(exp.cursor_row), 16'(got.cursor_row));
            compare_field("accepted", 16'(exp.accepted), 16'(got.accepted));
            compare_field("cell_char", 16'(exp.cell_char), 16'(got.cell_char));
            compare_field("cell_attr", 16'(exp.cell_attr), 16'(got.cell_attr));
        endfunction
    endclass

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_valid  = 1'b0;
    logic                           s_ready;
    ttw_pkg::req_t                  drv_word = '0;
    logic                           m_valid;
    logic                           m_ready  = 1'b0;
    ttw_pkg::result_t               mon_word;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [ttw_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ttw_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    terminal_scoreboard sb = new();

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 30;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    text_terminal_writer #(
        .LINE_WIDTH(LINE_WIDTH),
        .LINE_COUNT(LINE_COUNT)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (drv_word.operation),
        .s_char_code    (drv_word.char_code),
        .s_column       (drv_word.column),
        .s_row          (drv_word.row),
        .s_range_start  (drv_word.range_start),
        .s_range_end    (drv_word.range_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cursor_index (mon_word.cursor_index),
        .m_cursor_column(mon_word.cursor_column),
        .m_cursor_row   (mon_word.cursor_row),
        .m_accepted     (mon_word.accepted),
        .m_cell_char    (mon_word.cell_char),
        .m_cell_attr    (mon_word.cell_attr),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #6 aclk = ~aclk;

    // sample every handshake at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_word(mon_word);
            if (s_valid && s_ready) sb.note_word(drv_word);
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_served + 1;
            hold_left   = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // run limit
    initial begin
        #30_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic ttw_pkg::req_t pack_word(logic [ttw_pkg::OP_W-1:0] op, int ch,
                                                int col, int row, int start, int stop);
        ttw_pkg::req_t w;
        w.operation   = op;
        w.char_code   = ttw_pkg::CHAR_W'(ch);
        w.column      = ttw_pkg::COORD_W'(col);
        w.row         = ttw_pkg::COORD_W'(row);
        w.range_start = ttw_pkg::RANGE_W'(start);
        w.range_end   = ttw_pkg::RANGE_W'(stop);
        return w;
    endfunction

    // random word: unused fields carry noise, used fields follow the mix below
    function automatic ttw_pkg::req_t make_random_word();
        ttw_pkg::req_t w;
        int            sel;
        int            pick;
        w.operation   = ttw_pkg::OP_PUT;
        w.char_code   = ttw_pkg::CHAR_W'($urandom_range(0, 255));
        w.column      = ttw_pkg::COORD_W'($urandom_range(0, 255));
        w.row         = ttw_pkg::COORD_W'($urandom_range(0, 255));
        w.range_start = ttw_pkg::RANGE_W'($urandom_range(0, 2047));
        w.range_end   = ttw_pkg::RANGE_W'($urandom_range(0, 2047));
        sel  = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        if (sel < 50) begin
            w.operation = ttw_pkg::OP_PUT;
            if (pick < 6) w.char_code = ttw_pkg::NEWLINE_CODE;
        end else if (sel < 65) begin
            w.operation = ttw_pkg::OP_GOTO;
            if (pick >= 35) begin
                w.column = ttw_pkg::COORD_W'($urandom_range(0, LINE_WIDTH - 1));
                w.row    = ttw_pkg::COORD_W'($urandom_range(0, LINE_COUNT - 1));
            end else if (pick >= 10) begin
                // near the bottom so that puts run past the end
                w.column = ttw_pkg::COORD_W'($urandom_range(0, LINE_WIDTH - 1));
                w.row    = ttw_pkg::COORD_W'($urandom_range(LINE_COUNT - 2, LINE_COUNT - 1));
            end
        end else if (sel < 80) begin
            w.operation = ttw_pkg::OP_FILL;
            // mostly short ranges, a few long ones
            if (pick >= 3)
                w.range_end = ttw_pkg::RANGE_W'(int'(w.range_start) + $urandom_range(0, 24));
        end else begin
            w.operation = ttw_pkg::OP_READ;
            if (pick < 50)
                w.range_start = ttw_pkg::RANGE_W'(
                    (sb.cursor + SCREEN_SIZE - $urandom_range(0, 8)) % SCREEN_SIZE);
        end
        return w;
    endfunction

    // offer one word, with random sender gaps, until it is taken
    task automatic send_word(ttw_pkg::req_t w);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        drv_word <= w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_register(logic [ttw_pkg::CFG_IDX_W-1:0] index, int colour);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= {4'($urandom_range(0, 15)), 4'(colour)};
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // sender stops until every expected word has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0) @(negedge aclk);
        repeat (5) @(negedge aclk);
    endtask

    task automatic run_phase(int count, int tx_pct, int rx_pct, bit with_hold, bit with_pause);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < count; i++) begin
            if (with_hold && i == count / 2) hold_requests = hold_requests + 1;
            if (with_pause && i == count / 3) drain();
            send_word(make_random_word());
        end
        drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed words with the reset colours
        send_word(pack_word(ttw_pkg::OP_READ, 0, 0, 0, 0, 0));
        send_word(pack_word(ttw_pkg::OP_READ, 255, 255, 255, SCREEN_SIZE, 2047));
        send_word(pack_word(ttw_pkg::OP_READ, 0, 0, 0, 2047, 0));
        send_word(pack_word(ttw_pkg::OP_PUT, 255, 0, 0, 0, 0));
        send_word(pack_word(ttw_pkg::OP_PUT, 0, 0, 0, 0, 0));
        send_word(pack_word(ttw_pkg::OP_PUT, ttw_pkg::NEWLINE_CODE, 0, 0, 0, 0));
        send_word(pack_word(ttw_pkg::OP_READ, 0, 0, 0, 0, 0));
        send_word(pack_word(ttw_pkg::OP_GOTO, 0, LINE_WIDTH, 0, 0, 0));
        send_word(pack_word(ttw_pkg::OP_GOTO, 0, 0, LINE_COUNT, 0, 0));
        send_word(pack_word(ttw_pkg::OP_GOTO, 0, 255, 255, 0, 0));
        send_word(pack_word(ttw_pkg::OP_GOTO, 0, LINE_WIDTH - 1, LINE_COUNT - 1, 0, 0));
        // put on the last cell runs past the end
        send_word(pack_word(ttw_pkg::OP_PUT, 8'h41, 0, 0, 0, 0));
        send_word(pack_word(ttw_pkg::OP_READ, 0, 0, 0, SCREEN_SIZE - 1, 0));
        send_word(pack_word(ttw_pkg::OP_READ, 0, 0, 0, SCREEN_SIZE - LINE_WIDTH - 1, 0));
        // newline on the last line scrolls too
        send_word(pack_word(ttw_pkg::OP_PUT, ttw_pkg::NEWLINE_CODE, 0, 0, 0, 0));
        send_word(pack_word(ttw_pkg::OP_FILL, 0, 0, 0, 0, 0));
        send_word(pack_word(ttw_pkg::OP_FILL, 0, 0, 0, 5, 3));
        send_word(pack_word(ttw_pkg::OP_FILL, 0, 0, 0, SCREEN_SIZE - 10, 2047));
        send_word(pack_word(ttw_pkg::OP_READ, 0, 0, 0, SCREEN_SIZE - 5, 0));
        send_word(pack_word(ttw_pkg::OP_FILL, 0, 0, 0, 2047, 2047));
        send_word(pack_word(ttw_pkg::OP_GOTO, 0, 0, 0, 0, 0));
        send_word(pack_word(ttw_pkg::OP_FILL, 0, 0, 0, 0, SCREEN_SIZE));
        send_word(pack_word(ttw_pkg::OP_READ, 0, 0, 0, 0, 0));
        drain();

        // extreme colours, plus writes to indexes that do not exist
        write_register(ttw_pkg::CFG_FG, 0);
        write_register(ttw_pkg::CFG_BG, 15);
        write_register(8'd2, 5);
        write_register(8'hFF, 9);
        run_phase(340, 19, 82, 0, 0);

        write_register(ttw_pkg::CFG_FG, $urandom_range(0, 15));
        write_register(ttw_pkg::CFG_BG, $urandom_range(0, 15));
        run_phase(340, 82, 19, 0, 1);

        write_register(ttw_pkg::CFG_FG, 15);
        write_register(ttw_pkg::CFG_BG, 15);
        run_phase(350, 0, 0, 1, 0);

        repeat (50) @(posedge aclk);
        $display("tb: %0d words checked: put %0d, goto %0d, fill %0d, read %0d",
                 sb.checked, sb.op_count[ttw_pkg::OP_PUT], sb.op_count[ttw_pkg::OP_GOTO],
                 sb.op_count[ttw_pkg::OP_FILL], sb.op_count[ttw_pkg::OP_READ]);
        $display("tb: %0d scrolls, %0d rejected positions, %0d register writes",
                 sb.scrolls, sb.rejected, sb.reg_writes);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ttw_pkg.sv
sv/ttw_cell_ram.sv
sv/ttw_seq.sv
sv/text_terminal_writer.sv
bench/text_terminal_writer_tb.sv
